// ===== rtl/rfdb_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rfdb_pkg: shared types and constants
// Beat structs, register map codes and sideband types for the depth brush.
// ----------------------------------------------------------------------------
package rfdb_pkg;

    localparam int MAP_WIDTH  = 1024;
    localparam int MAP_HEIGHT = 1024;
    localparam int CELL_SHIFT = 5;
    localparam int DEPTH_MAX  = 255;

    localparam int SQ_STAGES  = 16;   // one root bit per stage
    localparam int DIV_STAGES = 16;   // one quotient bit per stage
    localparam int ADDR_W     = 5;

    typedef enum logic [2:0] {
        REG_CENTER_X      = 3'd0,
        REG_CENTER_Y      = 3'd1,
        REG_INNER_RADIUS  = 3'd2,
        REG_FALLOFF_WIDTH = 3'd3,
        REG_PEAK_HEIGHT   = 3'd4,
        REG_LOWER_MODE    = 3'd5
    } reg_idx_t;

    typedef struct packed {
        logic [9:0] cell_col;
        logic [9:0] cell_row;
        logic [7:0] depth_in;
    } in_beat_t;

    typedef struct packed {
        logic [7:0] depth_out;
        logic       changed;
    } out_beat_t;

    typedef struct packed {
        logic       inmap;
        logic [7:0] depth;
    } sq_side_t;

    typedef struct packed {
        logic        inmap;
        logic [7:0]  depth;
        logic        band;
        logic [15:0] height;
    } div_side_t;

endpackage

// ===== rtl/radial_falloff_depth_brush.sv =====
`timescale 1ns / 1ps
// Throughput: one cell per cycle while the result side is not stalled; every stage,
// including the 16-stage root and 16-stage divider pipelines, takes a new beat each cycle.
// A stall on the result side freezes the whole pipeline in place.
// Reset (aresetn low, synchronous) empties the pipeline and loads register defaults.
// ----------------------------------------------------------------------------
// radial_falloff_depth_brush: circular brush stamp with linear falloff
// Distance, floor square root, falloff height and raise/lower update of depth.
// ----------------------------------------------------------------------------
module radial_falloff_depth_brush (
    input  logic                          aclk,
    input  logic                          aresetn,
    // input cells
    input  logic                          s_valid,
    output logic                          s_ready,
    input  rfdb_pkg::in_beat_t            s_data,
    // results
    output logic                          m_valid,
    input  logic                          m_ready,
    output rfdb_pkg::out_beat_t           m_data,
    // configuration
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [rfdb_pkg::ADDR_W-1:0]   paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);
    import rfdb_pkg::*;

    // ---------------- configuration registers ----------------
    logic [14:0]        center_x_reg;
    logic [13:0]        center_y_reg;
    logic signed [15:0] inner_radius_reg;
    logic [15:0]        falloff_width_reg;
    logic [15:0]        peak_height_reg;
    logic               lower_mode_reg;
    reg_idx_t           reg_idx;

    assign pready  = 1'b1;
    assign reg_idx = reg_idx_t'(paddr[ADDR_W-1:2]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            center_x_reg      <= '0;
            center_y_reg      <= '0;
            inner_radius_reg  <= '0;
            falloff_width_reg <= 16'd1;
            peak_height_reg   <= '0;
            lower_mode_reg    <= 1'b0;
        end else if (psel && penable && pwrite && pready) begin
            case (reg_idx)
                REG_CENTER_X:      center_x_reg      <= pwdata[14:0];
                REG_CENTER_Y:      center_y_reg      <= pwdata[13:0];
                REG_INNER_RADIUS:  inner_radius_reg  <= pwdata[15:0];
                REG_FALLOFF_WIDTH: falloff_width_reg <= pwdata[15:0];
                REG_PEAK_HEIGHT:   peak_height_reg   <= pwdata[15:0];
                REG_LOWER_MODE:    lower_mode_reg    <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_CENTER_X:      prdata = {17'd0, center_x_reg};
            REG_CENTER_Y:      prdata = {18'd0, center_y_reg};
            REG_INNER_RADIUS:  prdata = {16'd0, inner_radius_reg};
            REG_FALLOFF_WIDTH: prdata = {16'd0, falloff_width_reg};
            REG_PEAK_HEIGHT:   prdata = {16'd0, peak_height_reg};
            REG_LOWER_MODE:    prdata = {31'd0, lower_mode_reg};
            default:           prdata = 32'd0;
        endcase
    end

    // ---------------- pipeline control ----------------
    // Advance every stage together whenever the output register can take a beat.
    logic en;
    assign en      = !m_valid || m_ready;
    assign s_ready = en;

    // Stage 1: offsets from the brush centre, kept as magnitudes.
    logic        s1_valid_reg;
    logic [14:0] s1_adx_reg, s1_ady_reg;
    sq_side_t    s1_side_reg;
    logic signed [16:0] dx, dy;
    logic [14:0] adx_next, ady_next;
    logic        inmap;

    always_comb begin
        dx = signed'({2'b00, center_x_reg})
           - signed'({2'b00, s_data.cell_col, CELL_SHIFT'(0)});
        dy = signed'({2'b00, center_y_reg, 1'b0})
           - signed'({2'b00, s_data.cell_row, CELL_SHIFT'(0)});
        adx_next = dx[16] ? 15'(-dx) : dx[14:0];
        ady_next = dy[16] ? 15'(-dy) : dy[14:0];
        inmap = ({1'b0, s_data.cell_col} < 11'(MAP_WIDTH))
             && ({1'b0, s_data.cell_row} < 11'(MAP_HEIGHT));
    end

    // Stage 2: squares. Stage 3: squared distance.
    logic        s2_valid_reg, s3_valid_reg;
    logic [29:0] s2_dx2_reg, s2_dy2_reg;
    sq_side_t    s2_side_reg, s3_side_reg;
    logic [30:0] s3_d2_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end else if (en) begin
            s1_valid_reg <= s_valid;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            s1_adx_reg        <= adx_next;
            s1_ady_reg        <= ady_next;
            s1_side_reg.inmap <= inmap;
            s1_side_reg.depth <= s_data.depth_in;
            s2_dx2_reg        <= s1_adx_reg * s1_adx_reg;
            s2_dy2_reg        <= s1_ady_reg * s1_ady_reg;
            s2_side_reg       <= s1_side_reg;
            s3_d2_reg         <= {1'b0, s2_dx2_reg} + {1'b0, s2_dy2_reg};
            s3_side_reg       <= s2_side_reg;
        end
    end

    // Root pipeline.
    logic        sq_valid;
    logic [15:0] sq_root;
    sq_side_t    sq_side;

    rfdb_isqrt u_isqrt (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (s3_valid_reg),
        .in_value  (s3_d2_reg),
        .in_side   (s3_side_reg),
        .out_valid (sq_valid),
        .out_root  (sq_root),
        .out_side  (sq_side)
    );

    // Stage A: classify the radius against the inner radius and the band edge.
    logic signed [17:0] ra_s, inner_s, outer_s, diff_s;
    logic               in_core, beyond;
    logic               sa_valid_reg;
    div_side_t          sa_side_reg;
    logic [15:0]        sa_diff_reg;

    always_comb begin
        ra_s    = signed'({2'b00, sq_root});
        inner_s = 18'(inner_radius_reg);
        outer_s = inner_s + signed'({2'b00, falloff_width_reg});
        diff_s  = outer_s - ra_s;
        in_core = ra_s < inner_s;
        beyond  = ra_s >= outer_s;
    end

    // Stage B: band numerator.
    logic        sb_valid_reg;
    div_side_t   sb_side_reg;
    logic [31:0] sb_num_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sa_valid_reg <= 1'b0;
            sb_valid_reg <= 1'b0;
        end else if (en) begin
            sa_valid_reg <= sq_valid;
            sb_valid_reg <= sa_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            sa_side_reg.inmap  <= sq_side.inmap;
            sa_side_reg.depth  <= sq_side.depth;
            sa_side_reg.band   <= !in_core && !beyond;
            sa_side_reg.height <= in_core ? peak_height_reg : 16'd0;
            // zero the numerator outside the band so the quotient is simply zero
            sa_diff_reg        <= (!in_core && !beyond) ? diff_s[15:0] : 16'd0;
            sb_num_reg         <= peak_height_reg * sa_diff_reg;
            sb_side_reg        <= sa_side_reg;
        end
    end

    // Divider pipeline.
    logic        dv_valid;
    logic [15:0] dv_quot;
    div_side_t   dv_side;

    rfdb_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (sb_valid_reg),
        .in_num    (sb_num_reg),
        .in_den    (falloff_width_reg),
        .in_side   (sb_side_reg),
        .out_valid (dv_valid),
        .out_quot  (dv_quot),
        .out_side  (dv_side)
    );

    // Output stage: apply the height in raise or lower mode.
    logic [15:0] height;
    logic [16:0] sum;
    logic [7:0]  cap, result;
    logic        m_valid_reg;
    out_beat_t   m_data_reg;

    always_comb begin
        height = dv_side.band ? dv_quot : dv_side.height;
        sum    = {9'd0, dv_side.depth} + {1'b0, height};
        cap    = (height > 16'(DEPTH_MAX)) ? 8'd0 : 8'(16'(DEPTH_MAX) - height);
        if (!dv_side.inmap) begin
            result = dv_side.depth;
        end else if (!lower_mode_reg) begin
            result = (sum > 17'(DEPTH_MAX)) ? 8'(DEPTH_MAX) : sum[7:0];
        end else begin
            result = (dv_side.depth > cap) ? cap : dv_side.depth;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (en) begin
            m_valid_reg <= dv_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            m_data_reg.depth_out <= result;
            m_data_reg.changed   <= result != dv_side.depth;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

// ===== rtl/rfdb_isqrt.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rfdb_isqrt: pipelined floor square root
// Digit-by-digit root of a 31-bit value, one result bit per register stage.
// ----------------------------------------------------------------------------
module rfdb_isqrt (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                en,
    input  logic                in_valid,
    input  logic [30:0]         in_value,
    input  rfdb_pkg::sq_side_t  in_side,
    output logic                out_valid,
    output logic [15:0]         out_root,
    output rfdb_pkg::sq_side_t  out_side
);
    import rfdb_pkg::*;

    logic [31:0] v_reg     [SQ_STAGES];
    logic [31:0] root_reg  [SQ_STAGES];
    sq_side_t    side_reg  [SQ_STAGES];
    logic        valid_reg [SQ_STAGES];
    logic [31:0] v_next    [SQ_STAGES];
    logic [31:0] root_next [SQ_STAGES];

    always_comb begin
        logic [31:0] pv;
        logic [31:0] pr;
        logic [31:0] trial;
        logic [31:0] bitw;
        for (int i = 0; i < SQ_STAGES; i++) begin
            pv    = (i == 0) ? {1'b0, in_value} : v_reg[(i == 0) ? 0 : i - 1];
            pr    = (i == 0) ? 32'd0 : root_reg[(i == 0) ? 0 : i - 1];
            bitw  = 32'd1 << (2 * (SQ_STAGES - 1 - i));
            trial = pr + bitw;
            if (pv >= trial) begin
                v_next[i]    = pv - trial;
                root_next[i] = (pr >> 1) + bitw;
            end else begin
                v_next[i]    = pv;
                root_next[i] = pr >> 1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < SQ_STAGES; i++) valid_reg[i] <= 1'b0;
        end else if (en) begin
            for (int i = 0; i < SQ_STAGES; i++)
                valid_reg[i] <= (i == 0) ? in_valid : valid_reg[(i == 0) ? 0 : i - 1];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < SQ_STAGES; i++) begin
                v_reg[i]    <= v_next[i];
                root_reg[i] <= root_next[i];
                side_reg[i] <= (i == 0) ? in_side : side_reg[(i == 0) ? 0 : i - 1];
            end
        end
    end

    assign out_valid = valid_reg[SQ_STAGES-1];
    assign out_root  = root_reg[SQ_STAGES-1][15:0];
    assign out_side  = side_reg[SQ_STAGES-1];

endmodule

// ===== rtl/rfdb_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rfdb_div: pipelined restoring divider
// 32-bit by 16-bit division whose quotient fits 16 bits, one bit per stage.
// ----------------------------------------------------------------------------
module rfdb_div (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                en,
    input  logic                in_valid,
    input  logic [31:0]         in_num,
    input  logic [15:0]         in_den,
    input  rfdb_pkg::div_side_t in_side,
    output logic                out_valid,
    output logic [15:0]         out_quot,
    output rfdb_pkg::div_side_t out_side
);
    import rfdb_pkg::*;

    logic [31:0] rem_reg   [DIV_STAGES];
    logic [15:0] den_reg   [DIV_STAGES];
    logic [15:0] quot_reg  [DIV_STAGES];
    div_side_t   side_reg  [DIV_STAGES];
    logic        valid_reg [DIV_STAGES];
    logic [31:0] rem_next  [DIV_STAGES];
    logic [15:0] quot_next [DIV_STAGES];
    logic [15:0] den_cur   [DIV_STAGES];

    always_comb begin
        logic [31:0] pr;
        logic [15:0] pq;
        logic [31:0] trial;
        for (int i = 0; i < DIV_STAGES; i++) begin
            pr         = (i == 0) ? in_num : rem_reg[(i == 0) ? 0 : i - 1];
            pq         = (i == 0) ? 16'd0 : quot_reg[(i == 0) ? 0 : i - 1];
            den_cur[i] = (i == 0) ? in_den : den_reg[(i == 0) ? 0 : i - 1];
            trial      = {16'd0, den_cur[i]} << (DIV_STAGES - 1 - i);
            quot_next[i] = pq;
            if (pr >= trial) begin
                rem_next[i] = pr - trial;
                quot_next[i][DIV_STAGES-1-i] = 1'b1;
            end else begin
                rem_next[i] = pr;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < DIV_STAGES; i++) valid_reg[i] <= 1'b0;
        end else if (en) begin
            for (int i = 0; i < DIV_STAGES; i++)
                valid_reg[i] <= (i == 0) ? in_valid : valid_reg[(i == 0) ? 0 : i - 1];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < DIV_STAGES; i++) begin
                rem_reg[i]  <= rem_next[i];
                quot_reg[i] <= quot_next[i];
                den_reg[i]  <= den_cur[i];
                side_reg[i] <= (i == 0) ? in_side : side_reg[(i == 0) ? 0 : i - 1];
            end
        end
    end

    assign out_valid = valid_reg[DIV_STAGES-1];
    assign out_quot  = quot_reg[DIV_STAGES-1];
    assign out_side  = side_reg[DIV_STAGES-1];

endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: depth brush stamp testbench
// Drives cell beats through the brush block while stepping through brush
// settings over the register port. A scoreboard predicts every new depth and
// changed flag from the current settings and checks the result beats in order.
// ----------------------------------------------------------------------------
module tb_top;
    import rfdb_pkg::*;

    // Predicts the stamped depth of each accepted cell and checks result beats.
    class depth_scoreboard;
        bit [14:0] cx;
        bit [13:0] cy;
        int        inner;
        bit [15:0] width;
        bit [15:0] peak;
        bit        lower;
        out_beat_t pending[$];
        int        errors;
        int        checked;

        function new();
            cx = 0; cy = 0; inner = 0; width = 1; peak = 0; lower = 0;
            errors = 0; checked = 0;
        endfunction

        function void set_reg(reg_idx_t idx, bit [31:0] v);
            case (idx)
                REG_CENTER_X:      cx = v[14:0];
                REG_CENTER_Y:      cy = v[13:0];
                REG_INNER_RADIUS:  inner = $signed(v[15:0]);
                REG_FALLOFF_WIDTH: width = v[15:0];
                REG_PEAK_HEIGHT:   peak = v[15:0];
                REG_LOWER_MODE:    lower = v[0];
                default: ;
            endcase
        endfunction

        function automatic longint floor_root(longint unsigned v);
            longint unsigned r, b;
            r = 0;
            b = 64'd1 << 62;
            while (b > v) b >>= 2;
            while (b != 0) begin
                if (v >= r + b) begin
                    v -= r + b;
                    r = (r >> 1) + b;
                end else begin
                    r >>= 1;
                end
                b >>= 2;
            end
            return longint'(r);
        endfunction

        function void note_cell(in_beat_t c);
            longint dx, dy, ra, outer;
            longint unsigned h;
            int res, cap;
            out_beat_t e;
            res = c.depth_in;
            if (c.cell_col < MAP_WIDTH && c.cell_row < MAP_HEIGHT) begin
                dx = longint'(cx) - (longint'(c.cell_col) << CELL_SHIFT);
                dy = (longint'(cy) << 1) - (longint'(c.cell_row) << CELL_SHIFT);
                ra = floor_root(longint'(dx * dx + dy * dy));
                outer = inner + longint'(width);
                if (ra < inner) h = peak;
                else if (ra >= outer) h = 0;
                else h = (longint'(peak) * (outer - ra)) / longint'(width);
                if (!lower) begin
                    res = (c.depth_in + h > DEPTH_MAX) ? DEPTH_MAX : c.depth_in + int'(h);
                end else begin
                    cap = DEPTH_MAX - ((h > DEPTH_MAX) ? DEPTH_MAX : int'(h));
                    if (c.depth_in > cap) res = cap;
                end
            end
            e.depth_out = res[7:0];
            e.changed = (res != c.depth_in);
            pending.push_back(e);
        endfunction

        function void check_result(out_beat_t got);
            out_beat_t e;
            checked++;
            if (pending.size() == 0) begin
                errors++;
                $display("%0t: unexpected result beat depth_out=%0d changed=%0d",
                         $time, got.depth_out, got.changed);
                return;
            end
            e = pending.pop_front();
            if (got.depth_out !== e.depth_out) begin
                errors++;
                $display("%0t: depth_out expected %0d actual %0d",
                         $time, e.depth_out, got.depth_out);
            end
            if (got.changed !== e.changed) begin
                errors++;
                $display("%0t: changed expected %0d actual %0d",
                         $time, e.changed, got.changed);
            end
        endfunction
    endclass

    localparam int LATENCY = 38;
    localparam longint CYCLE_LIMIT = 400000;

    logic aclk, aresetn;
    logic s_valid, s_ready, m_valid, m_ready;
    in_beat_t s_data;
    out_beat_t m_data;
    logic psel, penable, pwrite, pready;
    logic [ADDR_W-1:0] paddr;
    logic [31:0] pwdata, prdata;

    radial_falloff_depth_brush u_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    depth_scoreboard sb = new();
    longint cycles = 0;
    bit quiet = 0;       // last part of the run: no idling
    bit hold_off = 0;    // long receiver stall request
    int cells_sent = 0;

    initial begin
        aclk = 0;
        forever #5 aclk = ~aclk;
    end

    // Count cycles and stop a hung run.
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("radial_falloff_depth_brush verification failed");
            $finish;
        end
    end

    // Check every accepted result beat.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) sb.check_result(m_data);
    end

    // Receiver: random stall bursts, a long hold-off on request.
    initial begin
        int n;
        m_ready = 0;
        @(posedge aclk);
        forever begin
            if (hold_off) begin
                m_ready <= 0;
                repeat (300) @(posedge aclk);
                hold_off = 0;
            end else if (!quiet && $urandom_range(0, 3) == 0) begin
                n = $urandom_range(1, 13);
                m_ready <= 0;
                repeat (n) @(posedge aclk);
            end else begin
                m_ready <= 1;
                repeat ($urandom_range(1, 20)) @(posedge aclk);
            end
        end
    end

    task automatic reg_write(reg_idx_t idx, bit [31:0] v);
        psel <= 1; penable <= 0; pwrite <= 1;
        paddr <= ADDR_W'(4 * int'(idx)); pwdata <= v;
        @(posedge aclk);
        penable <= 1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        psel <= 0; penable <= 0; pwrite <= 0;
        sb.set_reg(idx, v);
    endtask

    task automatic load_brush(bit [31:0] x, bit [31:0] y, bit [31:0] r,
                              bit [31:0] w, bit [31:0] p, bit [31:0] m);
        reg_write(REG_CENTER_X, x);
        reg_write(REG_CENTER_Y, y);
        reg_write(REG_INNER_RADIUS, r);
        reg_write(REG_FALLOFF_WIDTH, w);
        reg_write(REG_PEAK_HEIGHT, p);
        reg_write(REG_LOWER_MODE, m);
    endtask

    // Offer one cell; hold it until accepted, idle bursts before it.
    task automatic send_cell(bit [9:0] col, bit [9:0] row, bit [7:0] d);
        in_beat_t c;
        if (!quiet && $urandom_range(0, 4) == 0) begin
            s_valid <= 0;
            repeat ($urandom_range(1, 13)) @(posedge aclk);
        end
        c.cell_col = col; c.cell_row = row; c.depth_in = d;
        s_valid <= 1;
        s_data <= c;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        sb.note_cell(c);
        cells_sent++;
    endtask

    // Drain: wait for all results, then let the pipe settle.
    task automatic drain();
        s_valid <= 0;
        while (sb.pending.size() != 0) @(posedge aclk);
        repeat (LATENCY + 4) @(posedge aclk);
    endtask

    // Cell near the brush centre so distances land in and around the band.
    task automatic send_near(int span);
        int c, r;
        c = int'(sb.cx >> CELL_SHIFT) + $urandom_range(0, 2 * span) - span;
        r = ((int'(sb.cy) << 1) >> CELL_SHIFT) + $urandom_range(0, 2 * span) - span;
        if (c < 0) c = 0;
        if (c > 1023) c = 1023;
        if (r < 0) r = 0;
        if (r > 1023) r = 1023;
        send_cell(c[9:0], r[9:0], 8'($urandom()));
    endtask

    initial begin
        int ph;
        aresetn = 0; s_valid = 0; s_data = '0;
        psel = 0; penable = 0; pwrite = 0; paddr = '0; pwdata = '0;
        repeat (11) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);

        // Directed: reset settings, then extreme brushes.
        send_cell(0, 0, 0);
        send_cell(1023, 1023, 255);
        drain();
        load_brush(32767, 16383, 32767, 65535, 65535, 0);
        send_cell(1023, 1023, 0);
        send_cell(0, 0, 255);
        send_cell(1023, 1023, 200);
        drain();
        // Negative inner radius: band only.
        load_brush(16000, 8000, 32'hFFFF8000, 65535, 300, 1);
        send_cell(500, 500, 255);
        send_cell(0, 1023, 128);
        send_cell(1023, 0, 0);
        drain();
        // Zero falloff width: hard-edged disc, no division.
        load_brush(3200, 1600, 64, 0, 100, 0);
        send_cell(100, 100, 10);
        send_cell(101, 100, 10);
        send_cell(103, 100, 10);
        drain();
        reg_write(REG_LOWER_MODE, 1);
        send_cell(100, 100, 200);
        send_cell(110, 110, 200);
        drain();
        // Peak height above 255 in lower mode: depth capped to zero.
        load_brush(0, 0, 100, 50, 1000, 1);
        send_cell(0, 0, 255);
        send_cell(4, 0, 255);
        send_cell(5, 0, 1);
        drain();

        // Long receiver hold-off so the pipe fills and stalls the input.
        load_brush(4000, 2000, 80, 200, 300, 0);
        hold_off = 1;
        repeat (100) send_near(6);
        drain();

        // Random phases with fresh settings, mostly near the brush.
        for (ph = 0; ph < 16; ph++) begin
            if (ph == 13) quiet = 1;
            case (ph % 4)
                0: load_brush($urandom(), $urandom(), $urandom_range(0, 400),
                              $urandom_range(1, 400), $urandom_range(0, 600), $urandom());
                1: load_brush($urandom(), $urandom(), $urandom(),
                              $urandom(), $urandom(), $urandom());
                2: load_brush($urandom(), $urandom(), $urandom_range(0, 200),
                              0, $urandom_range(0, 300), $urandom());
                default: load_brush($urandom(), $urandom(),
                              32'hFFFF0000 | $urandom_range(32'hFF00, 32'hFFFF),
                              $urandom_range(100, 2000), $urandom(), $urandom());
            endcase
            repeat (50) begin
                if ($urandom_range(0, 3) == 0) begin
                    send_cell(10'($urandom()), 10'($urandom()), 8'($urandom()));
                end else begin
                    send_near(12);
                end
            end
            drain();
        end

        $display("Stamped %0d cells over 21 brush settings, %0d result beats checked.",
                 cells_sent, sb.checked);
        $display("Settings covered raise/lower, zero and wide bands, negative radius, big peaks.");
        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("radial_falloff_depth_brush verification clean");
        end else begin
            $display("radial_falloff_depth_brush verification failed");
        end
        $finish;
    end
endmodule
